// ----- rtl/fss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fss_pkg: shared definitions for the Fourier sawtooth sample block
// Field widths, register indexes, reset values, the control bundle between
// sequencer and datapath, and the constant functions that build the sine table.
// ----------------------------------------------------------------------------
package fss_pkg;

	localparam int MAX_HARMONICS_DEF   = 16;
	localparam int PHASE_BITS_DEF      = 16;
	localparam int SINE_TABLE_BITS_DEF = 10;

	localparam int PHASE_W    = 16;
	localparam int AMP_W      = 16;
	localparam int HC_W       = 5;
	localparam int SAMPLE_W   = 18;
	localparam int SINE_W     = 16;
	localparam int ROM_W      = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HARMONIC_COUNT = 2'd1;

	localparam logic [AMP_W-1:0] AMP_RESET = 16'd4096;
	localparam logic [HC_W-1:0]  HC_RESET  = 5'd5;

	localparam longint INV_PI_Q32 = 64'd1367130551;

	typedef struct packed {
		logic acc_clr;
		logic acc_en;
		logic mul_final;
		logic abs_sum;
		logic abs_diff;
		logic rnd_sum;
		logic rnd_out;
	} fss_ctrl_t;

	function automatic longint mul_q30(longint a, logic [63:0] b);
		logic [63:0] m;
		logic [63:0] p;
		m = (a < 0) ? 64'(-a) : 64'(a);
		p = (m * b + 64'h2000_0000) >> 30;
		return (a < 0) ? -$signed(p) : $signed(p);
	endfunction

	function automatic logic [ROM_W-1:0] sine_entry(int i, int table_bits);
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] q;
		longint acc;
		longint s;
		u = 64'(i) << (32 - table_bits);
		u2 = (u * u + 64'h2000_0000) >> 30;
		acc = 172272;
		acc = -5026995 + mul_q30(acc, u2);
		acc = 85569306 + mul_q30(acc, u2);
		acc = -693598668 + mul_q30(acc, u2);
		acc = 1686629713 + mul_q30(acc, u2);
		s = mul_q30(acc, u);
		q = (s > 0) ? ((64'(s) + 64'h8000) >> 16) : 64'd0;
		if (q > 64'd16384) begin
			q = 64'd16384;
		end
		return q[ROM_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/fss_osc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fss_osc: harmonic phase accumulator and quarter-wave sine lookup
// Steps the phase by the input phase once per harmonic and returns the signed
// Q1.14 sine of the current harmonic phase through a registered table read.
// ----------------------------------------------------------------------------
module fss_osc #(
	parameter int PHASE_BITS      = fss_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = fss_pkg::SINE_TABLE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             load,
	input  wire logic                             step,
	input  wire logic [fss_pkg::PHASE_W-1:0]      phase,
	output logic signed [fss_pkg::SINE_W-1:0]     sin_s1
);

	localparam int QUARTER = 2 ** (SINE_TABLE_BITS - 2);
	localparam int AW      = SINE_TABLE_BITS - 1;

	logic [PHASE_BITS-1:0]           ph_in;
	logic [PHASE_BITS-1:0]           ph_q;
	logic [PHASE_BITS-1:0]           p_q;
	logic [SINE_TABLE_BITS-1:0]      idx;
	logic [fss_pkg::ROM_W-1:0]       rom [QUARTER+1];
	logic [1:0]                      quad;
	logic [AW-1:0]                   r_ext;
	logic [AW-1:0]                   addr;
	logic signed [fss_pkg::SINE_W-1:0] sval;

	generate
		if (PHASE_BITS >= fss_pkg::PHASE_W) begin : g_ph_wide
			assign ph_in = PHASE_BITS'(phase);
		end else begin : g_ph_narrow
			assign ph_in = phase[PHASE_BITS-1:0];
		end

		if (PHASE_BITS >= SINE_TABLE_BITS) begin : g_idx_shr
			assign idx = p_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
		end else begin : g_idx_shl
			assign idx = {p_q, {(SINE_TABLE_BITS - PHASE_BITS){1'b0}}};
		end

		for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
			assign rom[g] = fss_pkg::sine_entry(g, SINE_TABLE_BITS);
		end
	endgenerate

	always_comb begin
		quad  = idx[SINE_TABLE_BITS-1 -: 2];
		r_ext = {1'b0, idx[SINE_TABLE_BITS-3:0]};
		addr  = quad[0] ? (AW'(QUARTER) - r_ext) : r_ext;
		sval  = $signed({1'b0, rom[addr]});
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ph_q <= ph_in;
			p_q  <= ph_in;
		end else if (step) begin
			p_q <= p_q + ph_q;
		end
		if (step) begin
			sin_s1 <= quad[1] ? -sval : sval;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/fss_arith.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fss_arith: shared multiplier, accumulator, rounding and output register
// One signed multiplier weights each sine term and later scales by amplitude;
// a magnitude stage and a rounding stage finish the sum and the final result.
// ----------------------------------------------------------------------------
module fss_arith #(
	parameter int MAX_HARMONICS = fss_pkg::MAX_HARMONICS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire fss_pkg::fss_ctrl_t                     ctrl,
	input  wire logic signed [fss_pkg::SINE_W-1:0]      sin_s1,
	input  wire logic [$clog2(MAX_HARMONICS+1)-1:0]     harm_s1,
	input  wire logic [fss_pkg::AMP_W-1:0]              amplitude,
	input  wire logic                                   out_ready,
	output logic                                        out_valid,
	output logic                                        out_free,
	output logic signed [fss_pkg::SAMPLE_W-1:0]         sample
);

	localparam int NW   = $clog2(MAX_HARMONICS + 1);
	localparam int ACCW = 47 + NW;
	localparam int S16W = ACCW - 29;
	localparam int PW   = S16W + 32;
	localparam int VW   = PW + 1;

	localparam logic signed [VW-1:0] SAT_HI = (2 ** (fss_pkg::SAMPLE_W - 1)) - 1;
	localparam logic signed [VW-1:0] SAT_LO = -(2 ** (fss_pkg::SAMPLE_W - 1));

	logic [30:0]              wtab [MAX_HARMONICS+1];
	logic signed [S16W-1:0]   mul_a;
	logic signed [31:0]       mul_b;
	logic signed [PW-1:0]     prod_s2;
	logic signed [ACCW-1:0]   acc_q;
	logic signed [VW-1:0]     diff;
	logic signed [VW-1:0]     abs_in;
	logic [VW-1:0]            mag_q;
	logic                     neg_q;
	logic signed [S16W-1:0]   s16_q;
	logic [VW-1:0]            r30;
	logic [VW-1:0]            r16;
	logic signed [VW-1:0]     res;
	logic signed [VW-1:0]     res_sat;
	logic                     out_valid_q;

	generate
		for (genvar g = 0; g <= MAX_HARMONICS; g++) begin : g_wtab
			localparam int GD = (g == 0) ? 1 : g;
			localparam longint WV = (g == 0) ? 0 : (fss_pkg::INV_PI_Q32 + g / 2) / GD;
			assign wtab[g] = 31'(WV);
		end
	endgenerate

	always_comb begin
		mul_a = ctrl.mul_final ? s16_q
		                       : {{(S16W - fss_pkg::SINE_W){sin_s1[fss_pkg::SINE_W-1]}}, sin_s1};
		mul_b = ctrl.mul_final ? $signed({16'd0, amplitude}) : $signed({1'b0, wtab[harm_s1]});
		diff   = $signed(VW'({amplitude, 15'd0})) - VW'(prod_s2);
		abs_in = ctrl.abs_sum ? VW'(acc_q) : diff;
		r30 = (mag_q + (VW'(1) << 29)) >> 30;
		r16 = (mag_q + (VW'(1) << 15)) >> 16;
		res = neg_q ? -$signed(r16) : $signed(r16);
		if (res > SAT_HI) begin
			res_sat = SAT_HI;
		end else if (res < SAT_LO) begin
			res_sat = SAT_LO;
		end else begin
			res_sat = res;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= mul_a * mul_b;
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + ACCW'(prod_s2);
		end
		if (ctrl.abs_sum || ctrl.abs_diff) begin
			mag_q <= abs_in[VW-1] ? VW'(-abs_in) : VW'(abs_in);
			neg_q <= abs_in[VW-1];
		end
		if (ctrl.rnd_sum) begin
			s16_q <= neg_q ? -$signed(S16W'(r30)) : $signed(S16W'(r30));
		end
		if (ctrl.rnd_out) begin
			sample <= res_sat[fss_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.rnd_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

endmodule
`default_nettype wire

// ----- rtl/fss_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fss_seq: sequencer for the harmonic loop and the finishing steps
// Issues one harmonic per cycle, tracks the multiply pipeline, then walks the
// datapath through rounding, amplitude scaling and the output write.
// ----------------------------------------------------------------------------
module fss_seq #(
	parameter int MAX_HARMONICS = fss_pkg::MAX_HARMONICS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [fss_pkg::HC_W-1:0]             harmonic_count,
	input  wire logic                                 out_free,
	output logic                                      osc_load,
	output logic                                      osc_step,
	output logic [$clog2(MAX_HARMONICS+1)-1:0]        harm_s1,
	output fss_pkg::fss_ctrl_t                        ctrl
);

	localparam int NW = $clog2(MAX_HARMONICS + 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RUN   = 9'b000000010,
		S_DRAIN = 9'b000000100,
		S_ABS1  = 9'b000001000,
		S_RND1  = 9'b000010000,
		S_MUL2  = 9'b000100000,
		S_ABS2  = 9'b001000000,
		S_RND2  = 9'b010000000,
		S_SPARE = 9'b100000000
	} state_t;

	state_t          state_q;
	logic [NW-1:0]   n_q;
	logic [NW-1:0]   kc_q;
	logic [NW-1:0]   kc;
	logic            v1_q;
	logic            v2_q;
	logic            accept;

	always_comb begin
		if (32'(harmonic_count) > MAX_HARMONICS) begin
			kc = NW'(MAX_HARMONICS);
		end else begin
			kc = NW'(harmonic_count);
		end
		in_ready       = (state_q == S_IDLE);
		accept         = in_valid && in_ready;
		osc_load       = accept;
		osc_step       = (state_q == S_RUN);
		ctrl.acc_clr   = accept;
		ctrl.acc_en    = v2_q;
		ctrl.mul_final = (state_q == S_MUL2);
		ctrl.abs_sum   = (state_q == S_ABS1);
		ctrl.rnd_sum   = (state_q == S_RND1);
		ctrl.abs_diff  = (state_q == S_ABS2);
		ctrl.rnd_out   = (state_q == S_RND2) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			kc_q    <= '0;
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			harm_s1 <= '0;
		end else begin
			v1_q <= osc_step;
			v2_q <= v1_q;
			if (osc_step) begin
				harm_s1 <= n_q;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						kc_q    <= kc;
						n_q     <= NW'(1);
						state_q <= (kc == '0) ? S_ABS1 : S_RUN;
					end
				end
				S_RUN: begin
					n_q <= n_q + NW'(1);
					if (n_q == kc_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!v1_q) begin
						state_q <= S_ABS1;
					end
				end
				S_ABS1: state_q <= S_RND1;
				S_RND1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_ABS2;
				S_ABS2: state_q <= S_RND2;
				S_RND2: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/fourier_sawtooth_sample.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fourier_sawtooth_sample: band-limited sawtooth by Fourier-series synthesis
// Returns A/2 - (A/pi) * sum of sin(2*pi*n*phase)/n over the configured
// harmonics, in signed Q5.12, saturated to the output range.
//
//   Channel   Signals                              Direction  Payload
//   input     in_valid / in_ready                  in         phase [15:0]
//   output    out_valid / out_ready                out        sample [17:0]
//   config    cfg_write_en / cfg_index / cfg_data  in         amplitude, harmonic_count
//
// A transaction with K harmonics (K clamped to MAX_HARMONICS) runs to its result
// before the next input is taken: in_ready is high only in the idle state, which
// the sequencer reenters once the result is written. The single shared multiplier
// handles one harmonic per cycle and then the amplitude scaling. Reset restores
// amplitude 1.0 and five harmonics. A stalled output holds the last finishing step
// until the output register frees.
// ----------------------------------------------------------------------------
module fourier_sawtooth_sample #(
	parameter int MAX_HARMONICS   = fss_pkg::MAX_HARMONICS_DEF,
	parameter int PHASE_BITS      = fss_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = fss_pkg::SINE_TABLE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [fss_pkg::PHASE_W-1:0]          phase,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [fss_pkg::SAMPLE_W-1:0]       sample,
	input  wire logic                                 cfg_write_en,
	input  wire logic [fss_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [fss_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int NW = $clog2(MAX_HARMONICS + 1);

	logic [fss_pkg::AMP_W-1:0]           amplitude_q;
	logic [fss_pkg::HC_W-1:0]            harmonic_count_q;
	logic                                osc_load;
	logic                                osc_step;
	logic [NW-1:0]                       harm_s1;
	logic signed [fss_pkg::SINE_W-1:0]   sin_s1;
	logic                                out_free;
	fss_pkg::fss_ctrl_t                  ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q      <= fss_pkg::AMP_RESET;
			harmonic_count_q <= fss_pkg::HC_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				fss_pkg::REG_AMPLITUDE: begin
					amplitude_q <= cfg_data[fss_pkg::AMP_W-1:0];
				end
				fss_pkg::REG_HARMONIC_COUNT: begin
					harmonic_count_q <= cfg_data[fss_pkg::HC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	fss_seq #(
		.MAX_HARMONICS (MAX_HARMONICS)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.harmonic_count (harmonic_count_q),
		.out_free       (out_free),
		.osc_load       (osc_load),
		.osc_step       (osc_step),
		.harm_s1        (harm_s1),
		.ctrl           (ctrl)
	);

	fss_osc #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_osc (
		.clk    (clk),
		.load   (osc_load),
		.step   (osc_step),
		.phase  (phase),
		.sin_s1 (sin_s1)
	);

	fss_arith #(
		.MAX_HARMONICS (MAX_HARMONICS)
	) u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sin_s1    (sin_s1),
		.harm_s1   (harm_s1),
		.amplitude (amplitude_q),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_free  (out_free),
		.sample    (sample)
	);

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the Fourier sawtooth sample block
// Sends phases over the valid/ready input channel and writes amplitude and
// harmonic count through the register port while the block is idle. Each
// accepted phase is run through an independent fixed-point model of the
// band-limited sawtooth, and every returned sample is checked in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_TERMS = 16;
	localparam int TABLE_BITS = 10;
	localparam int QUARTER = 1 << (TABLE_BITS - 2);
	localparam int PHASE_SHIFT = fss_pkg::PHASE_W - TABLE_BITS;
	localparam longint RECIP_PI_Q32 = 64'd1367130551;
	localparam longint SAT_HIGH = 131071;
	localparam longint SAT_LOW = -131072;
	localparam logic [fss_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [fss_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct {
		logic [fss_pkg::PHASE_W-1:0] phase;
		logic signed [fss_pkg::SAMPLE_W-1:0] sample;
	} sample_expect_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [fss_pkg::PHASE_W-1:0] phase = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [fss_pkg::SAMPLE_W-1:0] sample;
	logic cfg_write_en = 1'b0;
	logic [fss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [fss_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [fss_pkg::AMP_W-1:0] cur_amplitude = fss_pkg::AMP_RESET;
	logic [fss_pkg::HC_W-1:0] cur_harmonics = fss_pkg::HC_RESET;
	longint sine_quarter [0:QUARTER];
	sample_expect_t expected_samples [$];
	sample_expect_t oldest;
	int error_count = 0;
	int cycle_count = 0;
	int hold_cnt = 0;
	logic steady_flow = 1'b0;

	fourier_sawtooth_sample dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.phase(phase),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample(sample),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic longint q30_mul(input longint a, input longint b);
		longint m;
		m = (a < 0) ? -a : a;
		m = (m * b + 64'sd536870912) >>> 30;
		return (a < 0) ? -m : m;
	endfunction

	function automatic longint round_away(input longint v, input int s);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (longint'(1) <<< (s - 1))) >>> s;
		return (v < 0) ? -m : m;
	endfunction

	function automatic void build_sine_quarter();
		longint u;
		longint u2;
		longint acc;
		longint s;
		longint q;
		for (int i = 0; i <= QUARTER; i++) begin
			u = longint'(i) <<< (32 - TABLE_BITS);
			u2 = (u * u + 64'sd536870912) >>> 30;
			acc = 172272;
			acc = -5026995 + q30_mul(acc, u2);
			acc = 85569306 + q30_mul(acc, u2);
			acc = -693598668 + q30_mul(acc, u2);
			acc = 1686629713 + q30_mul(acc, u2);
			s = q30_mul(acc, u);
			q = (s > 0) ? ((s + 32768) >>> 16) : 0;
			if (q > 16384) begin
				q = 16384;
			end
			sine_quarter[i] = q;
		end
	endfunction

	function automatic longint sine_at(input logic [TABLE_BITS-1:0] idx);
		logic [1:0] quad;
		int r;
		longint v;
		quad = idx[TABLE_BITS-1 -: 2];
		r = int'(idx[TABLE_BITS-3:0]);
		v = quad[0] ? sine_quarter[QUARTER - r] : sine_quarter[r];
		return quad[1] ? -v : v;
	endfunction

	function automatic sample_expect_t predict_sample(input logic [fss_pkg::PHASE_W-1:0] ph);
		int k;
		longint term_sum;
		longint wrapped;
		longint weight;
		longint s16;
		longint diff;
		longint res;
		sample_expect_t e;
		k = (int'(cur_harmonics) > MAX_TERMS) ? MAX_TERMS : int'(cur_harmonics);
		term_sum = 0;
		for (int n = 1; n <= k; n++) begin
			wrapped = (longint'(n) * longint'(ph)) & 64'hFFFF;
			weight = (RECIP_PI_Q32 + longint'(n / 2)) / longint'(n);
			term_sum += sine_at(TABLE_BITS'(wrapped >>> PHASE_SHIFT)) * weight;
		end
		s16 = round_away(term_sum, 30);
		diff = (longint'(cur_amplitude) <<< 15) - s16 * longint'(cur_amplitude);
		res = round_away(diff, 16);
		if (res > SAT_HIGH) begin
			res = SAT_HIGH;
		end
		if (res < SAT_LOW) begin
			res = SAT_LOW;
		end
		e.phase = ph;
		e.sample = res[fss_pkg::SAMPLE_W-1:0];
		return e;
	endfunction

	function automatic void apply_config(input logic [fss_pkg::CFG_IDX_W-1:0] idx,
			input logic [fss_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			fss_pkg::REG_AMPLITUDE: begin
				cur_amplitude = val[fss_pkg::AMP_W-1:0];
			end
			fss_pkg::REG_HARMONIC_COUNT: begin
				cur_harmonics = val[fss_pkg::HC_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady_flow) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end else begin
			return $urandom_range(4, 40);
		end
	endfunction

	always @(posedge clk) begin
		if (steady_flow) begin
			out_ready <= 1'b1;
			hold_cnt <= 0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else begin
			out_ready <= ~out_ready;
			hold_cnt <= out_ready ? pick_gap() : $urandom_range(0, 6);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** fourier_sawtooth_sample: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: sample with no transaction pending: expected none, actual %0d",
					$time, sample);
				error_count++;
			end else begin
				oldest = expected_samples.pop_front();
				if (sample !== oldest.sample) begin
					$display("%0t: phase 0x%04h: expected sample %0d, actual %0d",
						$time, oldest.phase, oldest.sample, sample);
					error_count++;
				end
			end
		end
	end

	task automatic send_phase(input logic [fss_pkg::PHASE_W-1:0] ph);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		phase <= ph;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		expected_samples.push_back(predict_sample(ph));
	endtask

	task automatic write_reg(input logic [fss_pkg::CFG_IDX_W-1:0] idx,
			input logic [fss_pkg::CFG_DATA_W-1:0] val);
		in_valid <= 1'b0;
		wait (expected_samples.size() == 0);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		apply_config(idx, val);
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic set_config(input logic [fss_pkg::CFG_DATA_W-1:0] amp,
			input logic [fss_pkg::CFG_DATA_W-1:0] harmonics);
		write_reg(fss_pkg::REG_AMPLITUDE, amp);
		write_reg(fss_pkg::REG_HARMONIC_COUNT, harmonics);
	endtask

	task automatic test_reset_defaults();
		send_phase(16'h0000);
		send_phase(16'hFFFF);
		send_phase(16'h8000);
		send_phase(16'h4000);
		send_phase(16'h0040);
	endtask

	task automatic test_harmonic_extremes();
		set_config(16'd4096, 16'd0);
		send_phase(16'h1234);
		set_config(16'hFFFF, 16'd16);
		send_phase(16'h0040);
		send_phase(16'hFFC0);
		set_config(16'hFFFF, 16'd1);
		send_phase(16'h4000);
		set_config(16'd0, 16'd16);
		send_phase(16'h2000);
		set_config(16'd4096, 16'd31);
		send_phase(16'h0800);
		send_phase(16'hF800);
		set_config(16'd12345, 16'd17);
		send_phase(16'h5555);
		// Only the low five bits of the written data reach the harmonic count.
		set_config(16'd4096, 16'hFFE3);
		send_phase(16'hAAAA);
	endtask

	task automatic test_unused_index();
		set_config(16'd8192, 16'd7);
		write_reg(REG_SPARE_2, 16'h0000);
		write_reg(REG_SPARE_3, 16'hFFFF);
		send_phase(16'h0001);
		send_phase(16'h7FFF);
		send_phase(16'hC000);
	endtask

	task automatic test_random_sweep();
		logic [fss_pkg::CFG_DATA_W-1:0] amp;
		logic [fss_pkg::CFG_DATA_W-1:0] harmonics;
		logic [fss_pkg::PHASE_W-1:0] ph;
		for (int round = 0; round < 19; round++) begin
			case ($urandom_range(0, 5))
				0: amp = 16'd0;
				1: amp = 16'hFFFF;
				2: amp = 16'd4096;
				default: amp = 16'($urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 9))
				0: harmonics = 16'd0;
				1: harmonics = 16'd16;
				2: harmonics = 16'($urandom_range(17, 31));
				default: harmonics = 16'($urandom_range(1, 15));
			endcase
			harmonics[15:fss_pkg::HC_W] = 11'($urandom_range(0, 2047));
			set_config(amp, harmonics);
			steady_flow = (round % 5 == 3);
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					case ($urandom_range(0, 3))
						0: ph = 16'h0000;
						1: ph = 16'hFFFF;
						2: ph = 16'h8000;
						default: ph = 16'($urandom_range(0, 255));
					endcase
				end else begin
					ph = 16'($urandom_range(0, 65535));
				end
				send_phase(ph);
			end
			steady_flow = 1'b0;
		end
	endtask

	initial begin
		build_sine_quarter();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_harmonic_extremes();
		test_unused_index();
		test_random_sweep();
		in_valid <= 1'b0;
		wait (expected_samples.size() == 0);
		repeat (40) @(posedge clk);
		if (error_count == 0) begin
			$display("** fourier_sawtooth_sample: PASSED **");
		end else begin
			$display("** fourier_sawtooth_sample: FAILED **");
		end
		$finish;
	end

endmodule

// ----- fourier_sawtooth_sample.f -----
rtl/fss_pkg.sv
rtl/fss_osc.sv
rtl/fss_arith.sv
rtl/fss_seq.sv
rtl/fourier_sawtooth_sample.sv
dv/tb_top.sv
